>>> hw/rtl/bms_pkg.sv
`default_nettype none

package bms_pkg;

    localparam int TIMER_WIDTH_DEFAULT = 16;
    localparam int MAX_CHOICES = 15;
    localparam int REG_WIDTH = 16;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int INDEX_WIDTH = 4;
    localparam int PHASE_WIDTH = 3;
    localparam int SIG_WIDTH = 3;
    localparam int CHOICE_CMP_WIDTH = 8;
    localparam int SHOW_LIMIT = 7;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_SELECT_MODE       = 3'd0,
        REG_HOLD_TICKS        = 3'd1,
        REG_CYCLE_TICKS       = 3'd2,
        REG_CONFIRM_TICKS     = 3'd3,
        REG_SELECT_WAIT_TICKS = 3'd4,
        REG_SIGNATURE_COUNT   = 3'd5,
        REG_PROGRAM_COUNT     = 3'd6
    } cfg_index_t;

    typedef enum logic [2:0] {
        LED_NONE   = 3'd0,
        LED_OFF    = 3'd1,
        LED_SHOW   = 3'd2,
        LED_FLASH3 = 3'd3,
        LED_FLASH4 = 3'd4
    } led_t;

    typedef enum logic [1:0] {
        BAL_NONE    = 2'd0,
        BAL_ENABLE  = 2'd1,
        BAL_DISABLE = 2'd2
    } bal_t;

    typedef struct packed {
        logic                   select_mode;
        logic [REG_WIDTH-1:0]   hold_ticks;
        logic [REG_WIDTH-1:0]   cycle_ticks;
        logic [REG_WIDTH-1:0]   confirm_ticks;
        logic [REG_WIDTH-1:0]   select_wait_ticks;
        logic [SIG_WIDTH-1:0]   signature_count;
        logic [INDEX_WIDTH-1:0] program_count;
    } cfg_t;

    typedef struct packed {
        logic                   busy_res;
        logic [PHASE_WIDTH-1:0] phase;
        logic [INDEX_WIDTH-1:0] current_index;
        led_t                   led_action;
        bal_t                   balance_action;
        logic                   light_pipe_active;
        logic                   teach_request;
        logic                   program_done;
        logic [INDEX_WIDTH-1:0] program_choice;
    } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/bms_if.sv
`default_nettype none

interface bms_in_if;
    logic valid;
    logic ready;
    logic button_pressed;

    modport source (output valid, output button_pressed, input ready);
    modport sink (input valid, input button_pressed, output ready);
endinterface

interface bms_out_if import bms_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic                   busy_res;
    logic [PHASE_WIDTH-1:0] phase;
    logic [INDEX_WIDTH-1:0] current_index;
    logic [2:0]             led_action;
    logic [1:0]             balance_action;
    logic                   light_pipe_active;
    logic                   teach_request;
    logic                   program_done;
    logic [INDEX_WIDTH-1:0] program_choice;

    modport source (
        output valid, output busy_res, output phase, output current_index,
        output led_action, output balance_action, output light_pipe_active,
        output teach_request, output program_done, output program_choice,
        input ready
    );
    modport sink (
        input valid, input busy_res, input phase, input current_index,
        input led_action, input balance_action, input light_pipe_active,
        input teach_request, input program_done, input program_choice,
        output ready
    );
endinterface

interface bms_cfg_if import bms_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic [CFG_INDEX_WIDTH-1:0] index;
    logic [REG_WIDTH-1:0]       data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/button_mode_sequencer.sv
// Results are registered in the output buffer; the next-state logic is combinational.
// Throughput: one button sample per cycle while the result buffer has room.
// A two-entry result buffer keeps the input open while one result waits downstream.
// Reset (rst_n low, asynchronous) returns to idle with index, timer and light-pipe flag at
// zero, clears the result buffer and restores the register defaults.
`default_nettype none

module button_mode_sequencer import bms_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEFAULT
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    bms_in_if.sink    button,
    bms_out_if.source result,
    bms_cfg_if.sink   cfg
);

    cfg_t    cfg_val;
    result_t res_next;
    logic    buf_not_full;
    logic    accept;

    assign button.ready = buf_not_full;
    assign accept = button.valid && buf_not_full;

    bms_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_val)
    );

    bms_core #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .button_pressed (button.button_pressed),
        .cfg            (cfg_val),
        .res_next       (res_next)
    );

    bms_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (res_next),
        .not_full  (buf_not_full),
        .result    (result)
    );

endmodule

`default_nettype wire

>>> hw/rtl/bms_cfg_regs.sv
`default_nettype none

module bms_cfg_regs import bms_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    bms_cfg_if.sink    cfg,
    output cfg_t       cfg_out
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign cfg_out = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_SELECT_MODE:       cfg_next.select_mode = cfg.data[0];
                REG_HOLD_TICKS:        cfg_next.hold_ticks = cfg.data;
                REG_CYCLE_TICKS:       cfg_next.cycle_ticks = cfg.data;
                REG_CONFIRM_TICKS:     cfg_next.confirm_ticks = cfg.data;
                REG_SELECT_WAIT_TICKS: cfg_next.select_wait_ticks = cfg.data;
                REG_SIGNATURE_COUNT:   cfg_next.signature_count = cfg.data[SIG_WIDTH-1:0];
                REG_PROGRAM_COUNT:     cfg_next.program_count = cfg.data[INDEX_WIDTH-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.select_mode       <= 1'b0;
            cfg_reg.hold_ticks        <= 16'd1000;
            cfg_reg.cycle_ticks       <= 16'd1000;
            cfg_reg.confirm_ticks     <= 16'd30000;
            cfg_reg.select_wait_ticks <= 16'd4000;
            cfg_reg.signature_count   <= 3'd7;
            cfg_reg.program_count     <= 4'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/bms_core.sv
`default_nettype none

module bms_core import bms_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEFAULT
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic accept,
    input  wire logic button_pressed,
    input  cfg_t      cfg,
    output result_t   res_next
);

    localparam int CMP_WIDTH = (TIMER_WIDTH > REG_WIDTH) ? TIMER_WIDTH : REG_WIDTH;

    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_HOLD    = 6'b000010,
        PH_CYCLE   = 6'b000100,
        PH_CONFIRM = 6'b001000,
        PH_COMMIT  = 6'b010000,
        PH_LOCKOUT = 6'b100000
    } state_t;

    state_t                 st_reg;
    state_t                 st_next;
    logic [INDEX_WIDTH-1:0] idx_reg;
    logic [INDEX_WIDTH-1:0] idx_next;
    logic [TIMER_WIDTH-1:0] el_reg;
    logic [TIMER_WIDTH-1:0] el_next;
    logic                   pf_reg;
    logic                   pf_next;

    logic                      few_programs;
    logic [TIMER_WIDTH-1:0]    el_inc;
    logic [INDEX_WIDTH:0]      idx_inc;
    logic [CHOICE_CMP_WIDTH-1:0] progs;
    logic                      hold_to;
    logic                      cycle_to;
    logic                      confirm_to;
    logic                      wait_to;
    led_t                      led;
    bal_t                      bal;
    logic                      teach;
    logic                      done;
    logic [INDEX_WIDTH-1:0]    choice;

    function automatic led_t show_led(input logic [INDEX_WIDTH-1:0] idx);
        show_led = (idx <= INDEX_WIDTH'(SHOW_LIMIT)) ? LED_SHOW : LED_NONE;
    endfunction

    function automatic logic [PHASE_WIDTH-1:0] phase_code(input state_t st);
        logic [PHASE_WIDTH-1:0] code;
        unique case (st)
            PH_HOLD:    code = 3'd1;
            PH_CYCLE:   code = 3'd2;
            PH_CONFIRM: code = 3'd3;
            PH_COMMIT:  code = 3'd4;
            PH_LOCKOUT: code = 3'd5;
            default:    code = 3'd0;
        endcase
        return code;
    endfunction

    assign few_programs = cfg.select_mode && (cfg.program_count <= 4'd1);
    assign el_inc = (el_reg == '1) ? el_reg : el_reg + 1'b1;
    assign idx_inc = {1'b0, idx_reg} + 1'b1;
    assign progs = (CHOICE_CMP_WIDTH'(cfg.program_count) > CHOICE_CMP_WIDTH'(MAX_CHOICES)) ?
                   CHOICE_CMP_WIDTH'(MAX_CHOICES) : CHOICE_CMP_WIDTH'(cfg.program_count);

    assign hold_to    = CMP_WIDTH'(el_inc) > CMP_WIDTH'(cfg.hold_ticks);
    assign cycle_to   = CMP_WIDTH'(el_inc) > CMP_WIDTH'(cfg.cycle_ticks);
    assign confirm_to = CMP_WIDTH'(el_inc) > CMP_WIDTH'(cfg.confirm_ticks);
    assign wait_to    = CMP_WIDTH'(el_inc) > CMP_WIDTH'(cfg.select_wait_ticks);

    always_comb
    begin
        st_next  = st_reg;
        idx_next = idx_reg;
        el_next  = el_reg;
        pf_next  = pf_reg;
        led      = LED_NONE;
        bal      = BAL_NONE;
        teach    = 1'b0;
        done     = 1'b0;
        choice   = '0;

        if (few_programs)
        begin
            done = 1'b1;
        end
        else
        begin
            el_next = el_inc;
            if (!cfg.select_mode)
            begin
                unique case (st_reg)
                    PH_IDLE:
                    begin
                        if (button_pressed)
                        begin
                            el_next = '0;
                            st_next = PH_HOLD;
                            led = LED_OFF;
                        end
                    end
                    PH_HOLD:
                    begin
                        if (!button_pressed)
                        begin
                            st_next = PH_IDLE;
                        end
                        else if (hold_to)
                        begin
                            idx_next = '0;
                            el_next = '0;
                            led = LED_SHOW;
                            st_next = PH_CYCLE;
                        end
                    end
                    PH_CYCLE:
                    begin
                        if (!button_pressed)
                        begin
                            led = LED_FLASH3;
                            el_next = '0;
                            if (idx_reg == '0)
                                bal = BAL_ENABLE;
                            else
                                pf_next = 1'b1;
                            st_next = PH_CONFIRM;
                        end
                        else if (cycle_to)
                        begin
                            el_next = '0;
                            idx_next = (idx_inc > (INDEX_WIDTH+1)'(cfg.signature_count)) ?
                                       '0 : idx_inc[INDEX_WIDTH-1:0];
                            led = show_led(idx_next);
                        end
                    end
                    PH_CONFIRM:
                    begin
                        if (button_pressed)
                        begin
                            el_next = '0;
                            st_next = PH_COMMIT;
                        end
                        else if (confirm_to)
                        begin
                            pf_next = 1'b0;
                            st_next = PH_IDLE;
                            led = LED_OFF;
                        end
                    end
                    PH_COMMIT:
                    begin
                        if (!button_pressed)
                        begin
                            pf_next = 1'b0;
                            st_next = PH_IDLE;
                            if (idx_reg == '0)
                            begin
                                bal = BAL_DISABLE;
                                led = LED_FLASH4;
                            end
                            else
                            begin
                                teach = 1'b1;
                                led = LED_OFF;
                            end
                        end
                        else if (hold_to)
                        begin
                            if (idx_reg == '0)
                                bal = BAL_DISABLE;
                            pf_next = 1'b0;
                            led = LED_OFF;
                            st_next = PH_LOCKOUT;
                        end
                    end
                    PH_LOCKOUT:
                    begin
                        if (!button_pressed)
                        begin
                            pf_next = 1'b0;
                            st_next = PH_IDLE;
                            led = LED_OFF;
                        end
                    end
                    default:
                    begin
                        pf_next = 1'b0;
                        st_next = PH_IDLE;
                        led = LED_OFF;
                    end
                endcase
            end
            else
            begin
                unique case (st_reg)
                    PH_IDLE:
                    begin
                        el_next = '0;
                        st_next = PH_HOLD;
                        led = show_led(idx_reg);
                    end
                    PH_HOLD:
                    begin
                        if (button_pressed)
                        begin
                            el_next = '0;
                            idx_next = INDEX_WIDTH'(1);
                            led = LED_SHOW;
                            st_next = PH_CYCLE;
                        end
                        else if (wait_to)
                        begin
                            pf_next = 1'b0;
                            st_next = PH_IDLE;
                            led = LED_FLASH4;
                            done = 1'b1;
                        end
                    end
                    PH_CYCLE:
                    begin
                        if (!button_pressed)
                        begin
                            choice = idx_reg;
                            pf_next = 1'b0;
                            st_next = PH_IDLE;
                            led = LED_FLASH4;
                            done = 1'b1;
                        end
                        else if (cycle_to)
                        begin
                            el_next = '0;
                            idx_next = (CHOICE_CMP_WIDTH'(idx_inc) > progs) ?
                                       INDEX_WIDTH'(1) : idx_inc[INDEX_WIDTH-1:0];
                            led = show_led(idx_next);
                        end
                    end
                    default:
                    begin
                        pf_next = 1'b0;
                        st_next = PH_IDLE;
                        led = LED_OFF;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        res_next.busy_res          = (st_next != PH_IDLE);
        res_next.phase             = phase_code(st_next);
        res_next.current_index     = idx_next;
        res_next.led_action        = led;
        res_next.balance_action    = bal;
        res_next.light_pipe_active = pf_next;
        res_next.teach_request     = teach;
        res_next.program_done      = done;
        res_next.program_choice    = choice;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= PH_IDLE;
            idx_reg <= '0;
            el_reg  <= '0;
            pf_reg  <= 1'b0;
        end
        else if (accept)
        begin
            st_reg  <= st_next;
            idx_reg <= idx_next;
            el_reg  <= el_next;
            pf_reg  <= pf_next;
        end
    end

    // With too few programs a transaction must leave the sequence state alone.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && few_programs |=> $stable(st_reg) && $stable(el_reg) && $stable(idx_reg))
        else $error("sequence state changed while program count is below two");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && res_next.teach_request |->
            !res_next.busy_res && res_next.current_index != '0 && !res_next.program_done)
        else $error("teach request without a return to idle on a nonzero index");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && res_next.program_choice != '0 |->
            res_next.program_done && cfg.select_mode)
        else $error("program choice given without a final select-mode choice");

endmodule

`default_nettype wire

>>> hw/rtl/bms_out_buf.sv
`default_nettype none

module bms_out_buf import bms_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  result_t   push_data,
    output logic      not_full,
    bms_out_if.source result
);

    result_t     slot_reg [2];
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic        pop;
    result_t     head;

    assign not_full = (count_reg != 2'd2);
    assign pop = result.valid && result.ready;
    assign head = slot_reg[rd_ptr_reg];

    assign result.valid             = (count_reg != 2'd0);
    assign result.busy_res          = head.busy_res;
    assign result.phase             = head.phase;
    assign result.current_index     = head.current_index;
    assign result.led_action        = 3'(head.led_action);
    assign result.balance_action    = 2'(head.balance_action);
    assign result.light_pipe_active = head.light_pipe_active;
    assign result.teach_request     = head.teach_request;
    assign result.program_done      = head.program_done;
    assign result.program_choice    = head.program_choice;

    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire
